FILE: rtl/ttx_pkg.sv
// Shared types and constants for the text terminal core.
// No dependencies; imported by the terminal top level.
package ttx_pkg;

   // Command codes carried on the request tuser field
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_PGUP  = 2'd2;
   localparam logic [1:0] CMD_PGDN  = 2'd3;

   // Escape parser modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESC    = 2'd1;
   localparam logic [1:0] MODE_CSI    = 2'd2;

   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] FIN_CUP  = 8'h48;  // H
   localparam logic [7:0] FIN_HVP  = 8'h66;  // f
   localparam logic [7:0] FIN_ED   = 8'h4A;  // J
   localparam logic [7:0] FIN_EL   = 8'h4B;  // K
   localparam logic [7:0] FIN_SGR  = 8'h6D;  // m
   localparam logic [7:0] FIN_SET  = 8'h68;  // h
   localparam logic [7:0] FIN_RST  = 8'h6C;  // l

   localparam logic [15:0] PRM_CURSOR = 16'd25;
   localparam logic [15:0] PRM_RESET  = 16'd0;
   localparam logic [15:0] PRM_SWAP   = 16'd7;
   localparam logic [15:0] PRM_CLEAR  = 16'd2;
   localparam logic [15:0] FG_LO = 16'd30;
   localparam logic [15:0] FG_HI = 16'd37;
   localparam logic [15:0] BG_LO = 16'd40;
   localparam logic [15:0] BG_HI = 16'd47;
   localparam logic [15:0] FGB_LO = 16'd90;
   localparam logic [15:0] FGB_HI = 16'd97;
   localparam logic [15:0] BGB_LO = 16'd100;
   localparam logic [15:0] BGB_HI = 16'd107;

   localparam logic [6:0] BLANK_CH = 7'd32;
   localparam logic [3:0] WHITE    = 4'd7;
   localparam logic [3:0] BLACK    = 4'd0;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;

   typedef struct packed {
      logic [6:0] ch;
      logic [3:0] fg;
      logic [3:0] bg;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

endpackage

FILE: rtl/ttx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ttx_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/ansi_text_terminal_with_scrollback_core.sv
// Character-cell terminal with CSI parser, scrollback ring and paged viewport.
// Depends on ttx_pkg and ttx_ram (live screen and scrollback memories).
//
//  channel | dir | handshake          | contents
//  req     | in  | tvalid/tready      | tuser: cmd; tdata: data_byte, view_row, view_col
//  rsp     | out | tvalid/tready      | tdata: cell, cursor, viewport and history status
//
// Steps: a plain byte, page command or parser step is accepted, executed and
// answered; a cell read adds a memory read wait; a color select walks its
// parameters one at a time. A scroll walks one row of the live memory into history.
// Erase to end of line walks from the cursor to the line end; a full clear sweeps the grid.
// After reset the live memory is swept blank, with req_tready low.
// A stalled response holds in its register while the next request is accepted.
module ansi_text_terminal_with_scrollback_core #(
   parameter int COLS          = 80,
   parameter int ROWS          = 25,
   parameter int HISTORY_LINES = 256,
   parameter int MAX_PARAMS    = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] data_byte, [12:8] view_row, [19:13] view_col
   input  logic [ttx_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] cmd
   input  logic [ttx_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [6:0] cell_char, [10:7] cell_fg, [14:11] cell_bg, [21:15] cursor_col,
   // [26:22] cursor_row, [27] cursor_shown, [36:28] view_offset, [45:37] history_lines
   output logic [ttx_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ttx_pkg::*;

   localparam int CW     = $clog2(COLS);
   localparam int RW     = $clog2(ROWS);
   localparam int LDEPTH = ROWS * COLS;
   localparam int LA     = $clog2(LDEPTH);
   localparam int HDEPTH = HISTORY_LINES * COLS;
   localparam int HA     = $clog2(HDEPTH);
   localparam int HCW    = $clog2(HISTORY_LINES + 1);
   localparam int HPW    = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
   localparam int PTW    = $clog2(MAX_PARAMS + 1);
   localparam int PIW    = $clog2(MAX_PARAMS);
   localparam int SW     = HCW + 6;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_EXEC   = 4'd2;
   localparam logic [3:0] S_RDWAIT = 4'd3;
   localparam logic [3:0] S_SCROLL = 4'd4;
   localparam logic [3:0] S_ERASE  = 4'd5;
   localparam logic [3:0] S_SGR    = 4'd6;
   localparam logic [3:0] S_DONE   = 4'd7;

   logic [3:0]     state_ff, state_in;
   logic           boot_ff, boot_in;
   logic [LA-1:0]  sweep_ff, sweep_in;
   logic [CW:0]    col_ff, col_in;
   logic [1:0]     cmd_ff, cmd_in;
   logic [7:0]     byte_ff, byte_in;
   logic [4:0]     vrow_ff, vrow_in;
   logic [6:0]     vcol_ff, vcol_in;
   logic [CW-1:0]  cur_col_ff, cur_col_in;
   logic [RW-1:0]  cur_row_ff, cur_row_in;
   logic [RW-1:0]  top_ff, top_in;
   logic [HPW-1:0] head_ff, head_in;
   logic [HCW-1:0] hcount_ff, hcount_in;
   logic [HCW-1:0] vback_ff, vback_in;
   logic [3:0]     pen_fg_ff, pen_fg_in, pen_bg_ff, pen_bg_in;
   logic [3:0]     clr_fg_ff, clr_fg_in, clr_bg_ff, clr_bg_in;
   logic           cursor_on_ff, cursor_on_in;
   logic [1:0]     mode_ff, mode_in;
   logic           priv_ff, priv_in;
   logic           digit_ff, digit_in;
   logic [PTW-1:0] ptotal_ff, ptotal_in;
   logic [15:0]    pv_ff [MAX_PARAMS];
   logic [15:0]    pv_in [MAX_PARAMS];
   logic [PTW-1:0] sgr_i_ff, sgr_i_in, sgr_n_ff, sgr_n_in;
   logic           rd_hist_ff, rd_hist_in, rd_blank_ff, rd_blank_in;
   cell_type       cell_ff, cell_in;
   logic           rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic           rsp_load;

   logic           live_we, live_re, hist_we, hist_re;
   logic [LA-1:0]  live_waddr, live_raddr;
   logic [HA-1:0]  hist_waddr, hist_raddr;
   cell_type       live_wdata, live_rdata, hist_wdata, hist_rdata;

   function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                              input logic [RW-1:0] r);
      logic [RW:0] s;
      s = {1'b0, top} + {1'b0, r};
      if (32'(s) >= ROWS) begin
         s = s - (RW+1)'(ROWS);
      end
      return s[RW-1:0];
   endfunction

   function automatic logic [LA-1:0] live_addr(input logic [RW-1:0] r,
                                               input logic [CW-1:0] c);
      return LA'(LA'(r) * LA'(COLS) + LA'(c));
   endfunction

   function automatic logic [HA-1:0] hist_addr(input logic [HPW-1:0] r,
                                               input logic [CW-1:0] c);
      return HA'(HA'(r) * HA'(COLS) + HA'(c));
   endfunction

   function automatic cell_type blank(input logic [3:0] fg, input logic [3:0] bg);
      cell_type c;
      c.ch = BLANK_CH;
      c.fg = fg;
      c.bg = bg;
      return c;
   endfunction

   ttx_ram #(.WIDTH(CELL_W), .DEPTH(LDEPTH)) u_live (
      .clock   (clock),
      .wr_en   (live_we),
      .wr_addr (live_waddr),
      .wr_data (live_wdata),
      .rd_en   (live_re),
      .rd_addr (live_raddr),
      .rd_data (live_rdata)
   );

   ttx_ram #(.WIDTH(CELL_W), .DEPTH(HDEPTH)) u_hist (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_en   (hist_re),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Working values for the execute step
   logic [CW:0]    ncol;
   logic [RW:0]    nrow;
   logic [PTW-1:0] te;
   logic [15:0]    pv_rd, pv0, pv1, rsel, csel;
   logic [PIW-1:0] pidx;
   logic [SW-1:0]  vsum, logical, lidx, pg_sum;
   logic [HPW:0]   ring;

   always_comb begin
      state_in     = state_ff;
      boot_in      = boot_ff;
      sweep_in     = sweep_ff;
      col_in       = col_ff;
      cmd_in       = cmd_ff;
      byte_in      = byte_ff;
      vrow_in      = vrow_ff;
      vcol_in      = vcol_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      top_in       = top_ff;
      head_in      = head_ff;
      hcount_in    = hcount_ff;
      vback_in     = vback_ff;
      pen_fg_in    = pen_fg_ff;
      pen_bg_in    = pen_bg_ff;
      clr_fg_in    = clr_fg_ff;
      clr_bg_in    = clr_bg_ff;
      cursor_on_in = cursor_on_ff;
      mode_in      = mode_ff;
      priv_in      = priv_ff;
      digit_in     = digit_ff;
      ptotal_in    = ptotal_ff;
      pv_in        = pv_ff;
      sgr_i_in     = sgr_i_ff;
      sgr_n_in     = sgr_n_ff;
      rd_hist_in   = rd_hist_ff;
      rd_blank_in  = rd_blank_ff;
      cell_in      = cell_ff;
      rsp_load     = 1'b0;

      live_we    = 1'b0;
      live_waddr = '0;
      live_wdata = blank(pen_fg_ff, pen_bg_ff);
      live_re    = 1'b0;
      live_raddr = '0;
      hist_we    = 1'b0;
      hist_waddr = '0;
      hist_wdata = live_rdata;
      hist_re    = 1'b0;
      hist_raddr = '0;

      pidx  = (state_ff == S_SGR) ? sgr_i_ff[PIW-1:0] : ptotal_ff[PIW-1:0];
      pv_rd = pv_ff[pidx];
      pv0   = pv_ff[0];
      pv1   = pv_ff[1];
      te    = ptotal_ff + PTW'(digit_ff);
      ncol  = {1'b0, cur_col_ff};
      nrow  = {1'b0, cur_row_ff};
      rsel  = '0;
      csel  = '0;
      vsum    = SW'(hcount_ff) + SW'(vrow_ff);
      logical = vsum - SW'(vback_ff);
      lidx    = logical - SW'(hcount_ff);
      ring    = (HPW+1)'(head_ff) + (HPW+1)'(logical);
      pg_sum  = SW'(vback_ff) + SW'(ROWS - 1);

      unique case (state_ff)
         S_CLEAR: begin
            live_we    = 1'b1;
            live_waddr = sweep_ff;
            live_wdata = blank(clr_fg_ff, clr_bg_ff);
            sweep_in   = sweep_ff + LA'(1);
            if (sweep_ff == LA'(LDEPTH - 1)) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? S_IDLE : S_DONE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser[1:0];
               byte_in  = req_tdata[7:0];
               vrow_in  = req_tdata[12:8];
               vcol_in  = req_tdata[19:13];
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            cell_in  = blank(WHITE, BLACK);
            state_in = S_DONE;
            unique case (cmd_ff)
               CMD_WRITE: begin
                  if (mode_ff == MODE_ESC) begin
                     if (byte_ff == CH_LBRK) begin
                        mode_in = MODE_CSI;
                     end else begin
                        mode_in   = MODE_NORMAL;
                        priv_in   = 1'b0;
                        digit_in  = 1'b0;
                        ptotal_in = '0;
                        pv_in[0]  = '0;
                     end
                  end else if (mode_ff == MODE_CSI) begin
                     if (byte_ff == CH_QUEST && !digit_ff && ptotal_ff == '0) begin
                        priv_in = 1'b1;
                     end else if (byte_ff >= CH_ZERO && byte_ff <= CH_NINE) begin
                        if (32'(ptotal_ff) < MAX_PARAMS) begin
                           pv_in[pidx] = (pv_rd << 3) + (pv_rd << 1)
                                       + 16'(byte_ff - CH_ZERO);
                           digit_in = 1'b1;
                        end
                     end else if (byte_ff == CH_SEMI) begin
                        if (32'(ptotal_ff) + 1 < MAX_PARAMS) begin
                           ptotal_in = ptotal_ff + PTW'(1);
                           pv_in[PIW'(ptotal_ff + PTW'(1))] = '0;
                        end
                     end else begin
                        // final byte: act, then drop back to normal text
                        mode_in   = MODE_NORMAL;
                        priv_in   = 1'b0;
                        digit_in  = 1'b0;
                        ptotal_in = '0;
                        pv_in[0]  = '0;
                        if (priv_ff) begin
                           if (te != '0 && pv0 == PRM_CURSOR) begin
                              if (byte_ff == FIN_RST) begin
                                 cursor_on_in = 1'b0;
                              end else if (byte_ff == FIN_SET) begin
                                 cursor_on_in = 1'b1;
                              end
                           end
                        end else if (byte_ff == FIN_CUP || byte_ff == FIN_HVP) begin
                           rsel = (te >= PTW'(1) && pv0 != '0) ? pv0 - 16'd1 : '0;
                           csel = (te >= PTW'(2) && pv1 != '0) ? pv1 - 16'd1 : '0;
                           if (32'(rsel) >= ROWS) begin
                              rsel = 16'(ROWS - 1);
                           end
                           if (32'(csel) >= COLS) begin
                              csel = 16'(COLS - 1);
                           end
                           cur_row_in = RW'(rsel);
                           cur_col_in = CW'(csel);
                        end else if (byte_ff == FIN_ED) begin
                           if (te == '0 || pv0 == PRM_CLEAR) begin
                              clr_fg_in  = pen_fg_ff;
                              clr_bg_in  = pen_bg_ff;
                              top_in     = '0;
                              cur_row_in = '0;
                              cur_col_in = '0;
                              sweep_in   = '0;
                              state_in   = S_CLEAR;
                           end
                        end else if (byte_ff == FIN_EL) begin
                           col_in   = {1'b0, cur_col_ff};
                           state_in = S_ERASE;
                        end else if (byte_ff == FIN_SGR) begin
                           if (te == '0) begin
                              pen_fg_in = WHITE;
                              pen_bg_in = BLACK;
                           end else begin
                              // hold the parameters until the color walk ends
                              mode_in   = MODE_CSI;
                              priv_in   = priv_ff;
                              digit_in  = digit_ff;
                              ptotal_in = ptotal_ff;
                              pv_in[0]  = pv0;
                              sgr_i_in  = '0;
                              sgr_n_in  = te;
                              state_in  = S_SGR;
                           end
                        end
                     end
                  end else if (byte_ff == CH_ESC) begin
                     mode_in = MODE_ESC;
                  end else begin
                     if (byte_ff == CH_LF) begin
                        ncol = '0;
                        nrow = nrow + (RW+1)'(1);
                     end else if (byte_ff == CH_CR) begin
                        ncol = '0;
                     end else if (byte_ff == CH_BS) begin
                        if (ncol != '0) begin
                           ncol = ncol - (CW+1)'(1);
                        end
                     end else if (byte_ff == CH_TAB) begin
                        ncol = (ncol + (CW+1)'(8)) & ~(CW+1)'(7);
                     end else if (byte_ff >= CH_SPACE && byte_ff < CH_DEL) begin
                        live_we    = 1'b1;
                        live_waddr = live_addr(phys_row(top_ff, cur_row_ff), cur_col_ff);
                        live_wdata.ch = byte_ff[6:0];
                        live_wdata.fg = pen_fg_ff;
                        live_wdata.bg = pen_bg_ff;
                        ncol = ncol + (CW+1)'(1);
                     end
                     if (32'(ncol) >= COLS) begin
                        ncol = '0;
                        nrow = nrow + (RW+1)'(1);
                     end
                     cur_col_in = ncol[CW-1:0];
                     if (32'(nrow) >= ROWS) begin
                        cur_row_in = RW'(ROWS - 1);
                        col_in     = '0;
                        state_in   = S_SCROLL;
                     end else begin
                        cur_row_in = nrow[RW-1:0];
                     end
                  end
               end

               CMD_READ: begin
                  rd_blank_in = 1'b1;
                  rd_hist_in  = 1'b0;
                  state_in    = S_RDWAIT;
                  if (32'(vrow_ff) < ROWS && 32'(vcol_ff) < COLS
                      && vsum >= SW'(vback_ff)) begin
                     if (logical < SW'(hcount_ff)) begin
                        if (32'(ring) >= HISTORY_LINES) begin
                           ring = ring - (HPW+1)'(HISTORY_LINES);
                        end
                        rd_blank_in = 1'b0;
                        rd_hist_in  = 1'b1;
                        hist_re     = 1'b1;
                        hist_raddr  = hist_addr(
                           (32'(hcount_ff) < HISTORY_LINES) ? HPW'(logical) : ring[HPW-1:0],
                           CW'(vcol_ff));
                     end else if (32'(lidx) < ROWS) begin
                        rd_blank_in = 1'b0;
                        live_re     = 1'b1;
                        live_raddr  = live_addr(phys_row(top_ff, RW'(lidx)), CW'(vcol_ff));
                     end
                  end
               end

               CMD_PGUP: begin
                  vback_in = (pg_sum > SW'(hcount_ff)) ? hcount_ff : HCW'(pg_sum);
               end

               CMD_PGDN: begin
                  vback_in = (SW'(vback_ff) > SW'(ROWS - 1))
                           ? HCW'(SW'(vback_ff) - SW'(ROWS - 1)) : '0;
               end

               default: begin
               end
            endcase
         end

         S_RDWAIT: begin
            if (!rd_blank_ff) begin
               cell_in = rd_hist_ff ? hist_rdata : live_rdata;
            end
            state_in = S_DONE;
         end

         S_SCROLL: begin
            // read column k of the top row while column k-1 goes to history and is blanked
            if (32'(col_ff) < COLS) begin
               live_re    = 1'b1;
               live_raddr = live_addr(top_ff, col_ff[CW-1:0]);
            end
            if (col_ff != '0) begin
               hist_we    = 1'b1;
               hist_waddr = hist_addr(head_ff, CW'(col_ff - (CW+1)'(1)));
               live_we    = 1'b1;
               live_waddr = live_addr(top_ff, CW'(col_ff - (CW+1)'(1)));
            end
            col_in = col_ff + (CW+1)'(1);
            if (32'(col_ff) == COLS) begin
               top_in  = (32'(top_ff) == ROWS - 1) ? '0 : top_ff + RW'(1);
               head_in = (32'(head_ff) == HISTORY_LINES - 1) ? '0 : head_ff + HPW'(1);
               if (32'(hcount_ff) < HISTORY_LINES) begin
                  hcount_in = hcount_ff + HCW'(1);
               end
               state_in = S_DONE;
            end
         end

         S_ERASE: begin
            live_we    = 1'b1;
            live_waddr = live_addr(phys_row(top_ff, cur_row_ff), col_ff[CW-1:0]);
            col_in     = col_ff + (CW+1)'(1);
            if (32'(col_ff) == COLS - 1) begin
               state_in = S_DONE;
            end
         end

         S_SGR: begin
            if (pv_rd == PRM_RESET) begin
               pen_fg_in = WHITE;
               pen_bg_in = BLACK;
            end else if (pv_rd == PRM_SWAP) begin
               pen_fg_in = pen_bg_ff;
               pen_bg_in = pen_fg_ff;
            end else if (pv_rd >= FG_LO && pv_rd <= FG_HI) begin
               pen_fg_in = 4'(pv_rd - FG_LO);
            end else if (pv_rd >= BG_LO && pv_rd <= BG_HI) begin
               pen_bg_in = 4'(pv_rd - BG_LO);
            end else if (pv_rd >= FGB_LO && pv_rd <= FGB_HI) begin
               pen_fg_in = 4'(pv_rd - FGB_LO + 16'd8);
            end else if (pv_rd >= BGB_LO && pv_rd <= BGB_HI) begin
               pen_bg_in = 4'(pv_rd - BGB_LO + 16'd8);
            end
            sgr_i_in = sgr_i_ff + PTW'(1);
            if (sgr_i_ff + PTW'(1) == sgr_n_ff) begin
               mode_in   = MODE_NORMAL;
               priv_in   = 1'b0;
               digit_in  = 1'b0;
               ptotal_in = '0;
               pv_in[0]  = '0;
               state_in  = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         boot_ff      <= 1'b1;
         sweep_ff     <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         top_ff       <= '0;
         head_ff      <= '0;
         hcount_ff    <= '0;
         vback_ff     <= '0;
         pen_fg_ff    <= WHITE;
         pen_bg_ff    <= BLACK;
         clr_fg_ff    <= WHITE;
         clr_bg_ff    <= BLACK;
         cursor_on_ff <= 1'b1;
         mode_ff      <= MODE_NORMAL;
         priv_ff      <= 1'b0;
         digit_ff     <= 1'b0;
         ptotal_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         sweep_ff     <= sweep_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         top_ff       <= top_in;
         head_ff      <= head_in;
         hcount_ff    <= hcount_in;
         vback_ff     <= vback_in;
         pen_fg_ff    <= pen_fg_in;
         pen_bg_ff    <= pen_bg_in;
         clr_fg_ff    <= clr_fg_in;
         clr_bg_ff    <= clr_bg_in;
         cursor_on_ff <= cursor_on_in;
         mode_ff      <= mode_in;
         priv_ff      <= priv_in;
         digit_ff     <= digit_in;
         ptotal_ff    <= ptotal_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff[0] <= '0;
      end else begin
         pv_ff[0] <= pv_in[0];
      end
      for (int i = 1; i < MAX_PARAMS; i++) begin
         pv_ff[i] <= pv_in[i];
      end
      col_ff      <= col_in;
      cmd_ff      <= cmd_in;
      byte_ff     <= byte_in;
      vrow_ff     <= vrow_in;
      vcol_ff     <= vcol_in;
      sgr_i_ff    <= sgr_i_in;
      sgr_n_ff    <= sgr_n_in;
      rd_hist_ff  <= rd_hist_in;
      rd_blank_ff <= rd_blank_in;
      cell_ff     <= cell_in;
      if (rsp_load) begin
         rsp_data_ff <= {2'b00, 9'(hcount_ff), 9'(vback_ff),
                         cursor_on_ff && vback_ff == '0,
                         5'(cur_row_ff), 7'(cur_col_ff),
                         cell_ff.bg, cell_ff.fg, cell_ff.ch};
      end
   end

   a_row_in_grid: assert property (@(posedge clock) disable iff (reset)
      32'(cur_row_ff) < ROWS && 32'(top_ff) < ROWS)
      else $error("cursor or top row outside the grid");

   a_view_in_history: assert property (@(posedge clock) disable iff (reset)
      vback_ff <= hcount_ff && 32'(hcount_ff) <= HISTORY_LINES)
      else $error("viewport paged past stored history");

   a_exec_progress: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |=> state_ff != S_IDLE)
      else $error("request dropped without a response");

   a_scroll_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCROLL && state_in == S_DONE |=> hcount_ff != '0)
      else $error("scroll left history empty");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the text terminal core: a cell-level predictor and
// directed and randomized request/response stream traffic. Depends on ttx_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
   import ttx_pkg::*;

   localparam int COLS = 80;
   localparam int ROWS = 25;
   localparam int HIST = 256;
   localparam int NPRM = 8;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [6:0] ch;
      logic [3:0] fg;
      logic [3:0] bg;
      logic [6:0] col;
      logic [4:0] row;
      logic       shown;
      logic [8:0] offset;
      logic [8:0] lines;
   } status_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   ansi_text_terminal_with_scrollback_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Terminal shadow state
   cell_type   screen [ROWS][COLS];
   cell_type   scrollback [HIST][COLS];
   int         sb_head, sb_count, view_back, cur_col, cur_row;
   logic [3:0] pen_fg, pen_bg;
   bit         cursor_on, priv, digit_seen;
   logic [1:0] mode;
   int         nparams;
   logic [15:0] params [NPRM];

   status_t status_fifo [$];
   int      errors = 0;
   int      send_idle_pct = 0, recv_idle_pct = 0;
   int      quiet_cycles = 0;

   function automatic cell_type blank(logic [3:0] fg, logic [3:0] bg);
      cell_type c;
      c.ch = BLANK_CH;
      c.fg = fg;
      c.bg = bg;
      return c;
   endfunction

   function automatic void term_reset();
      foreach (screen[r, c]) screen[r][c] = blank(WHITE, BLACK);
      foreach (params[i]) params[i] = '0;
      sb_head = 0; sb_count = 0; view_back = 0; cur_col = 0; cur_row = 0;
      pen_fg = WHITE; pen_bg = BLACK; cursor_on = 1;
      mode = MODE_NORMAL; priv = 0; digit_seen = 0; nparams = 0;
   endfunction

   function automatic void parser_idle();
      mode = MODE_NORMAL; priv = 0; digit_seen = 0; nparams = 0; params[0] = '0;
   endfunction

   function automatic void scroll_up();
      for (int c = 0; c < COLS; c++) scrollback[sb_head][c] = screen[0][c];
      sb_head = (sb_head + 1) % HIST;
      if (sb_count < HIST) sb_count++;
      for (int r = 0; r < ROWS - 1; r++)
         for (int c = 0; c < COLS; c++) screen[r][c] = screen[r+1][c];
      for (int c = 0; c < COLS; c++) screen[ROWS-1][c] = blank(pen_fg, pen_bg);
   endfunction

   function automatic void apply_final(logic [7:0] fin);
      int r, c;
      logic [15:0] p;
      logic [3:0] t;
      if (priv) begin
         if (nparams >= 1 && params[0] == PRM_CURSOR) begin
            if (fin == FIN_RST) cursor_on = 0;
            else if (fin == FIN_SET) cursor_on = 1;
         end
         return;
      end
      case (fin)
         FIN_CUP, FIN_HVP: begin
            r = (nparams >= 1 && params[0] > 0) ? int'(params[0]) - 1 : 0;
            c = (nparams >= 2 && params[1] > 0) ? int'(params[1]) - 1 : 0;
            if (r >= ROWS) r = ROWS - 1;
            if (c >= COLS) c = COLS - 1;
            cur_row = r; cur_col = c;
         end
         FIN_ED: begin
            if (nparams == 0 || params[0] == PRM_CLEAR) begin
               foreach (screen[i, j]) screen[i][j] = blank(pen_fg, pen_bg);
               cur_col = 0; cur_row = 0;
            end
         end
         FIN_EL: for (int j = cur_col; j < COLS; j++) screen[cur_row][j] = blank(pen_fg, pen_bg);
         FIN_SGR: begin
            if (nparams == 0) begin
               pen_fg = WHITE; pen_bg = BLACK;
            end
            for (int i = 0; i < nparams && i < NPRM; i++) begin
               p = params[i];
               if (p == PRM_RESET) begin
                  pen_fg = WHITE; pen_bg = BLACK;
               end else if (p == PRM_SWAP) begin
                  t = pen_fg; pen_fg = pen_bg; pen_bg = t;
               end else if (p >= FG_LO && p <= FG_HI) pen_fg = 4'(p - FG_LO);
               else if (p >= BG_LO && p <= BG_HI) pen_bg = 4'(p - BG_LO);
               else if (p >= FGB_LO && p <= FGB_HI) pen_fg = 4'(p - FGB_LO + 16'd8);
               else if (p >= BGB_LO && p <= BGB_HI) pen_bg = 4'(p - BGB_LO + 16'd8);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void escape_step(logic [7:0] b);
      if (mode == MODE_ESC) begin
         if (b == CH_LBRK) mode = MODE_CSI;
         else parser_idle();
         return;
      end
      if (b == CH_QUEST && !digit_seen && nparams == 0) begin
         priv = 1;
         return;
      end
      if (b >= CH_ZERO && b <= CH_NINE) begin
         if (nparams < NPRM) begin
            params[nparams] = params[nparams] * 16'd10 + 16'(b - CH_ZERO);
            digit_seen = 1;
         end
         return;
      end
      if (b == CH_SEMI) begin
         if (nparams + 1 < NPRM) begin
            nparams++;
            params[nparams] = '0;
         end
         return;
      end
      if (digit_seen) nparams++;
      apply_final(b);
      parser_idle();
   endfunction

   function automatic void term_write(logic [7:0] b);
      if (mode != MODE_NORMAL) begin
         escape_step(b);
         return;
      end
      if (b == CH_ESC) begin
         mode = MODE_ESC;
         return;
      end
      if (b == CH_LF) begin
         cur_col = 0; cur_row++;
      end else if (b == CH_CR) cur_col = 0;
      else if (b == CH_BS) begin
         if (cur_col > 0) cur_col--;
      end else if (b == CH_TAB) cur_col = (cur_col + 8) & ~7;
      else if (b >= CH_SPACE && b < CH_DEL) begin
         screen[cur_row][cur_col].ch = b[6:0];
         screen[cur_row][cur_col].fg = pen_fg;
         screen[cur_row][cur_col].bg = pen_bg;
         cur_col++;
      end
      if (cur_col >= COLS) begin
         cur_col = 0; cur_row++;
      end
      while (cur_row >= ROWS) begin
         scroll_up();
         cur_row--;
      end
   endfunction

   function automatic cell_type view_cell(int row, int col);
      int logical;
      if (row >= ROWS || col >= COLS) return blank(WHITE, BLACK);
      if (sb_count + row < view_back) return blank(WHITE, BLACK);
      logical = sb_count + row - view_back;
      if (logical < sb_count)
         return scrollback[(sb_count < HIST) ? logical : (sb_head + logical) % HIST][col];
      if (logical - sb_count >= ROWS) return blank(WHITE, BLACK);
      return screen[logical - sb_count][col];
   endfunction

   function automatic status_t term_step(logic [1:0] cmd, logic [7:0] b, int row, int col);
      status_t s;
      cell_type c;
      c = blank(WHITE, BLACK);
      case (cmd)
         CMD_WRITE: term_write(b);
         CMD_READ:  c = view_cell(row, col);
         CMD_PGUP:  view_back = (view_back + ROWS - 1 > sb_count) ? sb_count
                                                                  : view_back + ROWS - 1;
         default:   view_back = (view_back > ROWS - 1) ? view_back - (ROWS - 1) : 0;
      endcase
      s.ch = c.ch; s.fg = c.fg; s.bg = c.bg;
      s.col = 7'(cur_col); s.row = 5'(cur_row);
      s.shown = cursor_on && view_back == 0;
      s.offset = 9'(view_back); s.lines = 9'(sb_count);
      return s;
   endfunction

   task automatic send(logic [1:0] cmd, logic [7:0] b = 8'h00, logic [4:0] row = '0,
                       logic [6:0] col = '0);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, col, row, b};
      do @(posedge clock); while (!req_tready);
      status_fifo.push_back(term_step(cmd, b, row, col));
   endtask

   task automatic put_byte(logic [7:0] b);
      send(CMD_WRITE, b);
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (status_fifo.size() != 0) @(posedge clock);
   endtask

   // Escape sequence: ESC [ then the body text
   task automatic put_csi(string body);
      put_byte(CH_ESC);
      put_byte(CH_LBRK);
      put_text(body);
   endtask

   task automatic random_csi();
      string s;
      int n;
      logic [7:0] fins [8];
      fins = '{FIN_CUP, FIN_HVP, FIN_ED, FIN_EL, FIN_SGR, FIN_SET, FIN_RST, 8'h00};
      s = ($urandom_range(9) == 0) ? "?" : "";
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(4))
            0: s = {s, $sformatf("%0d", $urandom_range(30, 37))};
            1: s = {s, $sformatf("%0d", $urandom_range(40, 47))};
            2: s = {s, $sformatf("%0d", $urandom_range(90, 107))};
            3: s = {s, $sformatf("%0d", $urandom_range(0, 30))};
            default: s = {s, "25"};
         endcase
         if (i != n - 1) s = {s, ";"};
      end
      put_csi(s);
      put_byte((n == 1 && s[0] == "?") ? (($urandom_range(1)) ? FIN_SET : FIN_RST)
               : (($urandom_range(7) == 7) ? 8'($urandom_range(64, 126))
                                           : fins[$urandom_range(6)]));
   endtask

   task automatic random_read();
      if ($urandom_range(4) == 0) send(CMD_READ, 8'($urandom), 5'($urandom), 7'($urandom));
      else send(CMD_READ, 8'($urandom), 5'($urandom_range(ROWS - 1)),
                7'($urandom_range(COLS - 1)));
   endtask

   task automatic random_traffic(int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         if (k < 38) put_byte(8'($urandom_range(32, 126)));
         else if (k < 48) put_byte(CH_LF);
         else if (k < 53) put_byte(($urandom_range(2) == 0) ? CH_CR
                                   : ($urandom_range(1) ? CH_BS : CH_TAB));
         else if (k < 65) random_csi();
         else if (k < 83) random_read();
         else if (k < 90) send(CMD_PGUP, 8'($urandom));
         else if (k < 96) send(CMD_PGDN, 8'($urandom));
         else put_byte(8'($urandom));
      end
   endtask

   task automatic test_directed();
      put_byte(8'd255);
      put_byte(8'd0);
      put_byte(CH_DEL);
      put_text("A~ ");
      put_byte(CH_BS);
      put_byte(CH_TAB);
      put_csi("1;31;44m");
      put_text("Z");
      put_csi("7m");
      put_text("q");
      put_csi("m");
      put_byte(CH_ESC);
      put_text("xy");                    // dropped escape
      put_csi("99;200H");                // clamped position
      put_byte(CH_TAB);                  // tab past the edge
      put_csi("70000;5f");               // wrapping parameter
      put_csi("1;2;3;4;5;6;7;8;9;95;102m"); // too many parameters
      put_csi("K");
      put_csi("?25l");
      put_csi("?7h");                    // unsupported private mode
      put_csi("3z");                     // unknown final
      put_csi("?25h");
      send(CMD_READ, 8'h00, 5'd0, 7'd0);
      send(CMD_READ, 8'hFF, 5'd31, 7'd127);
      send(CMD_READ, 8'h00, 5'd24, 7'd79);
      send(CMD_READ, 8'h00, 5'd0, 7'd80);
      send(CMD_PGUP);
      send(CMD_PGDN);
      put_csi("2J");
      put_csi("J");
   endtask

   // Fill the scrollback past its depth, paging and reading on the way
   task automatic test_scrollback();
      for (int i = 0; i < 285; i++) begin
         if (i % 6 == 0) put_byte(8'($urandom_range(33, 126)));
         put_byte(CH_LF);
         if (i % 40 == 3) begin
            send(CMD_PGUP);
            random_read();
            send(CMD_READ, 8'h00, 5'd0, 7'd0);      // oldest stored line while history is small
            put_byte(CH_LF);                        // growth while paged back
            random_read();
            send(CMD_PGDN);
         end
      end
      repeat (14) send(CMD_PGUP);
      repeat (4) random_read();
      repeat (14) send(CMD_PGDN);
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      status_t e;
      status_t a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.ch = rsp_tdata[6:0];    a.fg = rsp_tdata[10:7];     a.bg = rsp_tdata[14:11];
         a.col = rsp_tdata[21:15]; a.row = rsp_tdata[26:22];   a.shown = rsp_tdata[27];
         a.offset = rsp_tdata[36:28]; a.lines = rsp_tdata[45:37];
         if (status_fifo.size() == 0) begin
            $display("%0t: unexpected response %h", $realtime, rsp_tdata);
            errors++;
         end else begin
            e = status_fifo.pop_front();
            if (e != a) begin
               $display("%0t: mismatch exp ch=%0d fg=%0d bg=%0d col=%0d row=%0d shown=%0d off=%0d hist=%0d",
                        $realtime, e.ch, e.fg, e.bg, e.col, e.row, e.shown, e.offset, e.lines);
               $display("%0t:          act ch=%0d fg=%0d bg=%0d col=%0d row=%0d shown=%0d off=%0d hist=%0d",
                        $realtime, a.ch, a.fg, a.bg, a.col, a.row, a.shown, a.offset, a.lines);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      term_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 14; recv_idle_pct = 63;
      test_directed();
      random_traffic(6);
      drain();

      send_idle_pct = 63; recv_idle_pct = 14;
      test_scrollback();
      random_traffic(6);
      drain();                           // hold off until every response is back

      send_idle_pct = 0; recv_idle_pct = 0;
      random_traffic(12);
      drain();
      repeat (2100) @(posedge clock);

      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
